// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, held off while reset is asserted.
`define BBT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define BBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bbt_pkg.sv =====
// Package for the bounded bag table: types and constants.
`timescale 1ns / 1ps

package bbt_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int REQ_W = 2;
	localparam int VAL_W = 32;
	localparam int CNT_FIELD_W = 5;
	localparam logic [CNT_FIELD_W-1:0] CNT_FIELD_MAX = 5'd31;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_COUNT  = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH_LAST,
		ST_COMMIT
	} state_t;

endpackage

// ===== hdl/bounded_bag_table.sv =====
// Bounded bag table: fixed-capacity multiset of 32-bit values with one scan comparator.
`timescale 1ns / 1ps

// Channel   Ports                                           Handshake
// --------  ----------------------------------------------  ----------------------------
// request   req_type, item_value                            start high, busy low
// result    success, match_count, size_after, now_empty     done high for one cycle
//
// From the accepting edge to the result, a request passes the scan (a read of each
// entry present before it, a compare behind each read, the close of the scan), the
// commit and the done cycle; an empty bag has no reads, a clear goes straight to the
// commit, and a remove that finds its value first reads the last entry for the swap.
// The scan is paced by the single RAM read port and the one comparator behind it.
// A new request may be accepted in the cycle that done is high.
// Reset empties the bag (count to zero); stored values are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.

module bounded_bag_table #(
	parameter int CAPACITY = bbt_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bbt_pkg::REQ_W-1:0]     req_type,
	input  logic signed [bbt_pkg::VAL_W-1:0] item_value,
	output logic                          done,
	output logic                          success,
	output logic [bbt_pkg::CNT_FIELD_W-1:0] match_count,
	output logic [bbt_pkg::CNT_FIELD_W-1:0] size_after,
	output logic                          now_empty
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	bbt_pkg::state_t state_q, state_d;

	// request latched at accept
	bbt_pkg::req_e_t         req_q;
	logic [bbt_pkg::VAL_W-1:0] val_q;

	// bag state
	logic [CW-1:0] entry_count_q;

	// scan bookkeeping
	logic [CW-1:0] iss_q;        // next entry to read
	logic          cmp_vld_s1;   // RAM data of the previous read is valid
	logic [AW-1:0] cmp_idx_s1;   // its index
	logic [CW-1:0] matches_q;
	logic          found_q;
	logic [AW-1:0] first_q;

	// result registers
	logic                            done_q;
	logic                            success_q;
	logic [bbt_pkg::CNT_FIELD_W-1:0] match_count_q;
	logic [bbt_pkg::CNT_FIELD_W-1:0] size_after_q;
	logic                            now_empty_q;

	// RAM port
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [bbt_pkg::VAL_W-1:0] ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [bbt_pkg::VAL_W-1:0] ram_rdata;

	// commit results
	logic          ok_c;
	logic [CW-1:0] count_new_c;
	logic [CW-1:0] matches_out_c;
	logic [CW-1:0] last_idx;

	logic accept;
	logic issue;
	logic scan_end;
	logic hit;

	assign accept   = start && (state_q == bbt_pkg::ST_IDLE);
	assign issue    = (state_q == bbt_pkg::ST_SCAN) && (iss_q < entry_count_q);
	assign scan_end = (iss_q == entry_count_q) && !cmp_vld_s1;
	assign hit      = cmp_vld_s1 && (ram_rdata == val_q);
	assign last_idx = CW'(entry_count_q - CW'(1));

	bbt_ram #(
		.WIDTH(bbt_pkg::VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bbt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (bbt_pkg::req_e_t'(req_type) == bbt_pkg::REQ_CLEAR) ?
						bbt_pkg::ST_COMMIT : bbt_pkg::ST_SCAN;
				end
			end
			bbt_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = (req_q == bbt_pkg::REQ_REMOVE && found_q) ?
						bbt_pkg::ST_FETCH_LAST : bbt_pkg::ST_COMMIT;
				end
			end
			bbt_pkg::ST_FETCH_LAST: state_d = bbt_pkg::ST_COMMIT;
			bbt_pkg::ST_COMMIT:     state_d = bbt_pkg::ST_IDLE;
			default:                state_d = bbt_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: RAM control and the commit decision
	always_comb begin
		ram_we        = 1'b0;
		ram_waddr     = first_q;
		ram_wdata     = ram_rdata;
		ram_raddr     = '0;
		ok_c          = 1'b0;
		count_new_c   = entry_count_q;
		matches_out_c = matches_q;
		unique case (state_q)
			bbt_pkg::ST_SCAN:       ram_raddr = iss_q[AW-1:0];
			bbt_pkg::ST_FETCH_LAST: ram_raddr = last_idx[AW-1:0];
			bbt_pkg::ST_COMMIT: begin
				unique case (req_q)
					bbt_pkg::REQ_ADD: begin
						if (entry_count_q < CW'(CAPACITY)) begin
							ram_we      = 1'b1;
							ram_waddr   = entry_count_q[AW-1:0];
							ram_wdata   = val_q;
							count_new_c = CW'(entry_count_q + CW'(1));
							ok_c        = 1'b1;
						end
					end
					bbt_pkg::REQ_REMOVE: begin
						// swap the last entry into the hole
						if (found_q) begin
							ram_we      = 1'b1;
							count_new_c = last_idx;
							ok_c        = 1'b1;
						end
					end
					bbt_pkg::REQ_COUNT: ok_c = (matches_q != '0);
					bbt_pkg::REQ_CLEAR: begin
						count_new_c   = '0;
						matches_out_c = '0;
						ok_c          = 1'b1;
					end
					default: ok_c = 1'b0;
				endcase
			end
			default: ram_raddr = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bbt_pkg::ST_IDLE;
			entry_count_q <= '0;
			iss_q         <= '0;
			cmp_vld_s1    <= 1'b0;
			found_q       <= 1'b0;
			matches_q     <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= (state_q == bbt_pkg::ST_COMMIT);
			cmp_vld_s1 <= issue;
			if (accept) begin
				iss_q     <= '0;
				found_q   <= 1'b0;
				matches_q <= '0;
			end else begin
				if (issue) begin
					iss_q <= CW'(iss_q + CW'(1));
				end
				if (hit) begin
					matches_q <= CW'(matches_q + CW'(1));
					found_q   <= 1'b1;
				end
			end
			if (state_q == bbt_pkg::ST_COMMIT) begin
				entry_count_q <= count_new_c;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= bbt_pkg::req_e_t'(req_type);
			val_q <= item_value;
		end
		if (issue) begin
			cmp_idx_s1 <= iss_q[AW-1:0];
		end
		if (hit && !found_q) begin
			first_q <= cmp_idx_s1;
		end
		if (state_q == bbt_pkg::ST_COMMIT) begin
			success_q     <= ok_c;
			match_count_q <= (32'(matches_out_c) > 32'(bbt_pkg::CNT_FIELD_MAX)) ?
				bbt_pkg::CNT_FIELD_MAX : bbt_pkg::CNT_FIELD_W'(matches_out_c);
			size_after_q  <= (32'(count_new_c) > 32'(bbt_pkg::CNT_FIELD_MAX)) ?
				bbt_pkg::CNT_FIELD_MAX : bbt_pkg::CNT_FIELD_W'(count_new_c);
			now_empty_q   <= (count_new_c == '0);
		end
	end

	assign busy        = (state_q != bbt_pkg::ST_IDLE);
	assign done        = done_q;
	assign success     = success_q;
	assign match_count = match_count_q;
	assign size_after  = size_after_q;
	assign now_empty   = now_empty_q;

endmodule

// ===== hdl/bbt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bbt_checker.sv =====
// Port-level checks for the bounded bag table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bbt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [bbt_pkg::CNT_FIELD_W-1:0] match_count,
	input logic [bbt_pkg::CNT_FIELD_W-1:0] size_after,
	input logic                            now_empty
);

	// a result comes back only once the sequencer has returned to idle
	`BBT_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result while busy")

	// an accepted request always starts work
	`BBT_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "accept without busy")

	// a result strobe lasts one cycle
	`BBT_ASSERT(a_done_pulse, clk, arst_n, done |=> !done, "done held two cycles")

	// empty flag agrees with the size field
	`BBT_ASSERT(a_empty_size, clk, arst_n, done |-> (now_empty == (size_after == '0)),
		"empty flag disagrees with size")

	// matches never exceed the size after the request plus one
	`BBT_ASSERT(a_match_bound, clk, arst_n,
		done |-> (6'(match_count) <= 6'(size_after) + 6'd1), "match count above size")

endmodule

bind bounded_bag_table bbt_checker u_bbt_checker (.*);

// ===== tb/bounded_bag_table_tb.sv =====
// Testbench for the bounded bag table: directed table plus random requests, each result checked.
`timescale 1ns / 1ps

module bounded_bag_table_tb;
	import bbt_pkg::*;

	localparam int BAG_CAP = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int CALM_TAIL = 60;          // last items go back to back
	localparam int MIX_SPAN = 40;           // items per random mix phase
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 2 * BAG_CAP + 10;

	// one result as seen on the result ports
	typedef struct packed {
		logic success;
		logic [CNT_FIELD_W-1:0] match_count;
		logic [CNT_FIELD_W-1:0] size_after;
		logic now_empty;
	} bag_reply_t;

	// directed row: when fixed is set, reply is the typed-in expectation
	typedef struct {
		req_e_t kind;
		logic [VAL_W-1:0] value;
		int reps;
		bit fixed;
		bag_reply_t reply;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [REQ_W-1:0] req_type;
	logic signed [VAL_W-1:0] item_value;
	logic done;
	logic success;
	logic [CNT_FIELD_W-1:0] match_count;
	logic [CNT_FIELD_W-1:0] size_after;
	logic now_empty;

	// shadow copy of the bag
	logic [VAL_W-1:0] bag_vals [BAG_CAP];
	int bag_len;

	bag_reply_t pending_replies [$];
	bag_reply_t reply_want;
	stim_row_t plan [$];
	logic [VAL_W-1:0] hot_vals [8];
	int fail_count = 0;
	int cycle_count = 0;

	bounded_bag_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.item_value (item_value),
		.done       (done),
		.success    (success),
		.match_count(match_count),
		.size_after (size_after),
		.now_empty  (now_empty)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// counts wider than the 5-bit fields pin at the field max
	function automatic logic [CNT_FIELD_W-1:0] sat_field(int n);
		return (n > int'(CNT_FIELD_MAX)) ? CNT_FIELD_MAX : CNT_FIELD_W'(n);
	endfunction

	// Apply one request to the shadow bag and return the reply it should give.
	// Matches are counted over the entries present before the request.
	function automatic bag_reply_t predict_reply(req_e_t kind, logic [VAL_W-1:0] v);
		bag_reply_t r;
		int hits;
		int first_hit;
		int i;
		logic ok;
		hits = 0;
		first_hit = -1;
		ok = 1'b0;
		for (i = 0; i < bag_len; i++) begin
			if (bag_vals[i] == v) begin
				if (first_hit < 0)
					first_hit = i;
				hits++;
			end
		end
		case (kind)
			REQ_ADD: begin
				if (bag_len < BAG_CAP) begin
					bag_vals[bag_len] = v;
					bag_len++;
					ok = 1'b1;
				end
			end
			REQ_REMOVE: begin
				// last entry moves into the hole
				if (first_hit >= 0) begin
					bag_len--;
					bag_vals[first_hit] = bag_vals[bag_len];
					ok = 1'b1;
				end
			end
			REQ_COUNT: begin
				ok = (hits != 0);
			end
			default: begin
				bag_len = 0;
				hits = 0;
				ok = 1'b1;
			end
		endcase
		r.success = ok;
		r.match_count = sat_field(hits);
		r.size_after = sat_field(bag_len);
		r.now_empty = (bag_len == 0);
		return r;
	endfunction

	// Called just after a falling edge. Optionally idles first, then holds start
	// until the item is taken, logs the expected reply, and returns at the next
	// falling edge. start stays high between items unless a gap first drops it.
	task automatic send_item(req_e_t kind, logic [VAL_W-1:0] v, bit fixed,
			bag_reply_t typed, bit gaps_on);
		bag_reply_t predicted;
		int gap;
		if (gaps_on && $urandom_range(3) == 0) begin
			gap = $urandom_range(10, 1);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		item_value <= v;
		// busy read here is the value just before the edge
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = predict_reply(kind, v);
		pending_replies.push_back(fixed ? typed : predicted);
		@(negedge clk);
	endtask

	// Result checker: done marks a one-cycle result that cannot be held off.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_replies.size() == 0) begin
				$error("result with no pending request");
				fail_count++;
			end else begin
				reply_want = pending_replies.pop_front();
				if (success !== reply_want.success) begin
					$error("success: expected %0d, actual %0d", reply_want.success, success);
					fail_count++;
				end
				if (match_count !== reply_want.match_count) begin
					$error("match_count: expected %0d, actual %0d",
						reply_want.match_count, match_count);
					fail_count++;
				end
				if (size_after !== reply_want.size_after) begin
					$error("size_after: expected %0d, actual %0d",
						reply_want.size_after, size_after);
					fail_count++;
				end
				if (now_empty !== reply_want.now_empty) begin
					$error("now_empty: expected %0d, actual %0d",
						reply_want.now_empty, now_empty);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int p;
		int r;
		int n;
		int mix;
		int roll;
		bit gaps_on;
		req_e_t kind;
		logic [VAL_W-1:0] v;

		start = 1'b0;
		req_type = REQ_ADD;
		item_value = '0;
		arst_n = 1'b0;
		bag_len = 0;

		// small value pool so adds, removes and counts hit each other;
		// the corners of the signed range are always in it
		hot_vals[0] = 32'h0000_0000;
		hot_vals[1] = 32'hFFFF_FFFF;
		hot_vals[2] = 32'h8000_0000;
		hot_vals[3] = 32'h7FFF_FFFF;
		for (p = 4; p < 8; p++)
			hot_vals[p] = $urandom();

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table: empty-bag corners, signed extremes, swap on remove,
		// full bag with every entry equal, add when full, remove with no match,
		// clear with its value ignored.
		plan.push_back('{REQ_COUNT,  32'h0000_0000, 1, 1'b1, '{1'b0, 5'd0, 5'd0, 1'b1}});
		plan.push_back('{REQ_REMOVE, 32'h0000_0005, 1, 1'b1, '{1'b0, 5'd0, 5'd0, 1'b1}});
		plan.push_back('{REQ_CLEAR,  32'hFFFF_FFFF, 1, 1'b1, '{1'b1, 5'd0, 5'd0, 1'b1}});
		plan.push_back('{REQ_ADD,    32'h8000_0000, 1, 1'b1, '{1'b1, 5'd0, 5'd1, 1'b0}});
		plan.push_back('{REQ_ADD,    32'h7FFF_FFFF, 1, 1'b1, '{1'b1, 5'd0, 5'd2, 1'b0}});
		plan.push_back('{REQ_COUNT,  32'h8000_0000, 1, 1'b1, '{1'b1, 5'd1, 5'd2, 1'b0}});
		plan.push_back('{REQ_COUNT,  32'h7FFF_FFFE, 1, 1'b1, '{1'b0, 5'd0, 5'd2, 1'b0}});
		plan.push_back('{REQ_REMOVE, 32'h7FFF_FFFF, 1, 1'b1, '{1'b1, 5'd1, 5'd1, 1'b0}});
		plan.push_back('{REQ_REMOVE, 32'h8000_0000, 1, 1'b1, '{1'b1, 5'd1, 5'd0, 1'b1}});
		plan.push_back('{REQ_ADD,    32'h5555_5555, BAG_CAP, 1'b0, '0});
		plan.push_back('{REQ_COUNT,  32'h5555_5555, 1, 1'b1, '{1'b1, 5'd16, 5'd16, 1'b0}});
		plan.push_back('{REQ_ADD,    32'h5555_5555, 1, 1'b1, '{1'b0, 5'd16, 5'd16, 1'b0}});
		plan.push_back('{REQ_REMOVE, 32'h1234_5678, 1, 1'b1, '{1'b0, 5'd0, 5'd16, 1'b0}});
		plan.push_back('{REQ_REMOVE, 32'h5555_5555, 1, 1'b1, '{1'b1, 5'd16, 5'd15, 1'b0}});
		plan.push_back('{REQ_CLEAR,  32'hAAAA_AAAA, 1, 1'b1, '{1'b1, 5'd0, 5'd0, 1'b1}});
		plan.push_back('{REQ_ADD,    32'hFFFF_FFFF, 1, 1'b1, '{1'b1, 5'd0, 5'd1, 1'b0}});
		plan.push_back('{REQ_COUNT,  32'h0000_0000, 1, 1'b1, '{1'b0, 5'd0, 5'd1, 1'b0}});

		foreach (plan[i])
			for (r = 0; r < plan[i].reps; r++)
				send_item(plan[i].kind, plan[i].value, plan[i].fixed, plan[i].reply, 1'b1);

		// Random part in phases: fill-heavy, drain-heavy and balanced mixes so
		// the bag swings between empty and full. Clear stays rare.
		mix = 0;
		gaps_on = 1'b1;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % MIX_SPAN == 0) begin
				mix = $urandom_range(2);
				gaps_on = ($urandom_range(3) != 0);
			end
			if (n >= RANDOM_ITEMS - CALM_TAIL)
				gaps_on = 1'b0;

			roll = $urandom_range(99);
			case (mix)
				0:       kind = (roll < 60) ? REQ_ADD : (roll < 80) ? REQ_REMOVE :
						(roll < 96) ? REQ_COUNT : REQ_CLEAR;
				1:       kind = (roll < 25) ? REQ_ADD : (roll < 75) ? REQ_REMOVE :
						(roll < 97) ? REQ_COUNT : REQ_CLEAR;
				default: kind = (roll < 40) ? REQ_ADD : (roll < 70) ? REQ_REMOVE :
						(roll < 97) ? REQ_COUNT : REQ_CLEAR;
			endcase

			// mostly pool values, some fully random words for bit coverage
			if ($urandom_range(9) < 7)
				v = hot_vals[$urandom_range(7)];
			else
				v = $urandom();

			send_item(kind, v, 1'b0, '0, gaps_on);
		end
		start <= 1'b0;

		// drain outstanding results, then let the block settle
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bbt_pkg.sv
hdl/bbt_ram.sv
hdl/bounded_bag_table.sv
hdl/bbt_checker.sv
tb/bounded_bag_table_tb.sv
